// ----- rtl/spvg_pkg.sv -----
// shared constants, types and tables of the star polygon vertex generator
`timescale 1ns / 1ps
`default_nettype none

package spvg_pkg;

    localparam int MAX_BRANCHES      = 32;
    localparam int MIN_BRANCHES      = 3;
    localparam int COORD_FRAC_BITS   = 15;
    localparam int CORDIC_ITERATIONS = 16;

    localparam int BRANCH_W = 6;
    localparam int RATIO_W  = 17;
    localparam int IDX_W    = 6;
    localparam int COORD_W  = 16;

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(65536);

    localparam int ANGLE_W   = 32;
    localparam int QUAD_LSB  = 30;
    localparam int ATAN_W    = 30;
    localparam int CORDIC_W  = 36;
    localparam int Z_W       = 33;
    localparam int PROD_W    = CORDIC_W + RATIO_W + 1;
    localparam int RATIO_SH  = 16;
    localparam int SCL_W     = PROD_W - RATIO_SH;
    localparam int DIV_STEPS = 32;
    localparam int IT_W      = 5;

    localparam logic [ANGLE_W-1:0] ANGLE_OFF = ANGLE_W'(64'd1 << 30);
    localparam logic signed [CORDIC_W-1:0] GAIN_Q32 = CORDIC_W'(64'sd2608131497);

    localparam int     OUT_SHIFT = 32 - COORD_FRAC_BITS;
    localparam longint OUT_RND   = longint'(1) << (31 - COORD_FRAC_BITS);
    localparam longint FRAC_HI   = (longint'(1) << COORD_FRAC_BITS) - 1;
    localparam longint FRAC_LO   = -(longint'(1) << COORD_FRAC_BITS);
    localparam longint OUT_HI    = (FRAC_HI > 32767) ? 32767 : FRAC_HI;
    localparam longint OUT_LO    = (FRAC_LO < -32768) ? -32768 : FRAC_LO;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_ROT   = 6'b001000,
        S_SCALE = 6'b010000,
        S_PUSH  = 6'b100000
    } t_state;

    typedef struct packed {
        logic latch;
        logic div_step;
        logic load;
        logic rot_step;
        logic scale;
        logic push;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic div_last;
        logic rot_last;
        logic out_free;
        logic last_vtx;
    } t_sts;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [ATAN_W-1:0] atan_turn(input logic [IT_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            5'd24:   v = 30'd41;
            5'd25:   v = 30'd20;
            5'd26:   v = 30'd10;
            5'd27:   v = 30'd5;
            5'd28:   v = 30'd3;
            5'd29:   v = 30'd1;
            5'd30:   v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/spvg_req_if.sv -----
// request channel: branch count and inner radius ratio
`timescale 1ns / 1ps
`default_nettype none

interface spvg_req_if;
    import spvg_pkg::*;

    logic                valid;
    logic                ready;
    logic [BRANCH_W-1:0] branch_count;
    logic [RATIO_W-1:0]  inner_radius;

    modport source (output valid, output branch_count, output inner_radius, input ready);
    modport sink   (input valid, input branch_count, input inner_radius, output ready);
endinterface

`default_nettype wire

// ----- rtl/spvg_vtx_if.sv -----
// vertex channel: one star vertex per beat
`timescale 1ns / 1ps
`default_nettype none

interface spvg_vtx_if;
    import spvg_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [IDX_W-1:0]          vertex_index;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      last_vertex;

    modport source (output valid, output vertex_index, output x_coord, output y_coord,
                    output last_vertex, input ready);
    modport sink   (input valid, input vertex_index, input x_coord, input y_coord,
                    input last_vertex, output ready);
endinterface

`default_nettype wire

// ----- rtl/spvg_ctrl.sv -----
// sequencing state machine of the star polygon vertex generator
`timescale 1ns / 1ps
`default_nettype none

module spvg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  spvg_pkg::t_sts i_sts,
    output spvg_pkg::t_cmd o_cmd
);
    import spvg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_ROT;
            end
            S_ROT: begin
                o_cmd.rot_step = 1'b1;
                if (i_sts.rot_last) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_PUSH;
            end
            S_PUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    if (i_sts.last_vtx) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/spvg_dp.sv -----
// datapath: step divider, angle accumulator, cordic rotator, scaling and output register
`timescale 1ns / 1ps
`default_nettype none

module spvg_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  spvg_pkg::t_cmd                     i_cmd,
    output spvg_pkg::t_sts                     o_sts,
    input  logic [spvg_pkg::BRANCH_W-1:0]      i_branch_count,
    input  logic [spvg_pkg::RATIO_W-1:0]       i_inner_radius,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [spvg_pkg::IDX_W-1:0]         o_vertex_index,
    output logic signed [spvg_pkg::COORD_W-1:0] o_x_coord,
    output logic signed [spvg_pkg::COORD_W-1:0] o_y_coord,
    output logic                               o_last_vertex
);
    import spvg_pkg::*;

    // request
    logic [BRANCH_W-1:0] r_n;
    logic [RATIO_W-1:0]  r_ratio;
    logic [BRANCH_W-1:0] w_n_clamp;
    logic [RATIO_W-1:0]  w_ratio_clamp;

    // step divider and shared iteration counter
    logic [IT_W-1:0]     r_it;
    logic [BRANCH_W-1:0] r_drem;
    logic [ANGLE_W-1:0]  r_dquo;
    logic [BRANCH_W:0]   w_dtry;
    logic                w_dge;

    // vertex position
    logic [IDX_W-1:0]    r_k;
    logic [ANGLE_W-1:0]  r_vq;
    logic [BRANCH_W-1:0] r_vr;
    logic [BRANCH_W:0]   w_vsum;
    logic                w_vge;
    logic [ANGLE_W-1:0]  w_angle;
    logic [IDX_W-1:0]    w_last_k;

    // cordic
    logic signed [CORDIC_W-1:0] r_cx;
    logic signed [CORDIC_W-1:0] r_cy;
    logic signed [Z_W-1:0]      r_cz;
    logic [1:0]                 r_quad;
    logic signed [CORDIC_W-1:0] w_dx;
    logic signed [CORDIC_W-1:0] w_dy;
    logic signed [Z_W-1:0]      w_atan;
    logic signed [CORDIC_W-1:0] w_c;
    logic signed [CORDIC_W-1:0] w_s;

    // scaling
    logic signed [PROD_W-1:0] w_px;
    logic signed [PROD_W-1:0] w_py;
    logic signed [PROD_W-1:0] w_ratio_s;
    logic signed [SCL_W-1:0]  r_vx;
    logic signed [SCL_W-1:0]  r_vy;
    logic                     r_inner;

    // output register
    logic                      r_ov;
    logic [IDX_W-1:0]          r_oidx;
    logic signed [COORD_W-1:0] r_ox;
    logic signed [COORD_W-1:0] r_oy;
    logic                      r_olast;

    function automatic logic signed [COORD_W-1:0] to_coord(input logic signed [SCL_W-1:0] v);
        logic signed [SCL_W-1:0] w;
        logic signed [SCL_W-1:0] t;
        w = v + SCL_W'(OUT_RND);
        t = w >>> OUT_SHIFT;
        if (t > SCL_W'(OUT_HI)) begin
            t = SCL_W'(OUT_HI);
        end else if (t < SCL_W'(OUT_LO)) begin
            t = SCL_W'(OUT_LO);
        end
        return COORD_W'(t);
    endfunction

    always_comb begin
        if (i_branch_count < BRANCH_W'(MIN_BRANCHES)) begin
            w_n_clamp = BRANCH_W'(MIN_BRANCHES);
        end else if (i_branch_count > BRANCH_W'(MAX_BRANCHES)) begin
            w_n_clamp = BRANCH_W'(MAX_BRANCHES);
        end else begin
            w_n_clamp = i_branch_count;
        end
        w_ratio_clamp = (i_inner_radius > RATIO_ONE) ? RATIO_ONE : i_inner_radius;
    end

    // restoring division of 2^31 by n, one quotient bit per cycle
    assign w_dtry = {r_drem, (r_it == '0)};
    assign w_dge  = (w_dtry >= {1'b0, r_n});

    // k*2^31/n advances by quotient and remainder of 2^31/n
    assign w_vsum   = {1'b0, r_vr} + {1'b0, r_drem};
    assign w_vge    = (w_vsum >= {1'b0, r_n});
    assign w_angle  = r_vq + ANGLE_OFF;
    assign w_last_k = IDX_W'({r_n, 1'b0} - 7'd1);

    assign w_dx   = r_cy >>> r_it;
    assign w_dy   = r_cx >>> r_it;
    assign w_atan = $signed({{(Z_W-ATAN_W){1'b0}}, atan_turn(r_it)});

    always_comb begin
        case (r_quad)
            2'd0: begin
                w_c = r_cx;
                w_s = r_cy;
            end
            2'd1: begin
                w_c = -r_cy;
                w_s = r_cx;
            end
            2'd2: begin
                w_c = -r_cx;
                w_s = -r_cy;
            end
            default: begin
                w_c = r_cy;
                w_s = -r_cx;
            end
        endcase
    end

    assign w_ratio_s = $signed({{(PROD_W-RATIO_W){1'b0}}, r_ratio});
    assign w_px      = PROD_W'(w_c) * w_ratio_s + PROD_W'(32768);
    assign w_py      = PROD_W'(w_s) * w_ratio_s + PROD_W'(32768);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_n     <= w_n_clamp;
            r_ratio <= w_ratio_clamp;
            r_drem  <= '0;
            r_dquo  <= '0;
            r_k     <= '0;
            r_vq    <= '0;
            r_vr    <= w_n_clamp >> 1;
        end
        if (i_cmd.div_step) begin
            r_drem <= w_dge ? BRANCH_W'(w_dtry - {1'b0, r_n}) : BRANCH_W'(w_dtry);
            r_dquo <= {r_dquo[ANGLE_W-2:0], w_dge};
        end
        if (i_cmd.latch || i_cmd.load) begin
            r_it <= '0;
        end else if (i_cmd.div_step || i_cmd.rot_step) begin
            r_it <= r_it + 1'b1;
        end
        if (i_cmd.load) begin
            r_cx    <= GAIN_Q32;
            r_cy    <= '0;
            r_cz    <= $signed({{(Z_W-QUAD_LSB){1'b0}}, w_angle[QUAD_LSB-1:0]});
            r_quad  <= w_angle[ANGLE_W-1:QUAD_LSB];
            r_inner <= r_k[0];
        end
        if (i_cmd.rot_step) begin
            if (!r_cz[Z_W-1]) begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_cz <= r_cz - w_atan;
            end else begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_cz <= r_cz + w_atan;
            end
        end
        if (i_cmd.scale) begin
            if (r_inner) begin
                r_vx <= w_px[PROD_W-1:RATIO_SH];
                r_vy <= w_py[PROD_W-1:RATIO_SH];
            end else begin
                r_vx <= SCL_W'(w_c);
                r_vy <= SCL_W'(w_s);
            end
        end
        if (i_cmd.advance) begin
            r_k  <= r_k + 1'b1;
            r_vr <= w_vge ? BRANCH_W'(w_vsum - {1'b0, r_n}) : BRANCH_W'(w_vsum);
            r_vq <= r_vq + r_dquo + ANGLE_W'(w_vge);
        end
        if (i_cmd.push) begin
            r_oidx  <= r_k;
            r_ox    <= to_coord(r_vx);
            r_oy    <= to_coord(r_vy);
            r_olast <= (r_k == w_last_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.push) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_sts.div_last = (r_it == IT_W'(DIV_STEPS - 1));
    assign o_sts.rot_last = (r_it == IT_W'(CORDIC_ITERATIONS - 1));
    assign o_sts.out_free = !r_ov || i_out_ready;
    assign o_sts.last_vtx = (r_k == w_last_k);

    assign o_out_valid    = r_ov;
    assign o_vertex_index = r_oidx;
    assign o_x_coord      = r_ox;
    assign o_y_coord      = r_oy;
    assign o_last_vertex  = r_olast;

endmodule

`default_nettype wire

// ----- rtl/star_polygon_vertex_generator.sv -----
// top level of the star polygon vertex generator
// usage:
//   i_req takes one beat per request: branch_count (clamped to 3..32) and
//   inner_radius (unsigned Q1.16, saturated to 1.0). o_vtx then gives the 2n
//   vertices of the star in index order, vertex k at angle pi/2 + k*pi/n,
//   even indexes on the unit circle and odd ones scaled by the ratio, x and y
//   in signed Q1.15. last_vertex marks the final beat of the request.
// timing:
//   a request beat starts a division of 2^31 by n; each vertex then passes
//   in turn through angle load, 16 cordic rotation steps, ratio scaling and
//   output load on the single shared cordic rotator, which works on one
//   vertex at a time.
//   i_req.ready is high only while no request is in work; the next request
//   is taken as soon as the last vertex sits in the output register.
// stalls and reset:
//   o_vtx has an output register; while it is full and not taken the next
//   finished vertex waits and the rotator halts. Reset drops the vertex valid
//   and returns the controller to idle; the datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module star_polygon_vertex_generator (
    input  logic     i_clk,
    input  logic     i_rst_n,
    spvg_req_if.sink   i_req,
    spvg_vtx_if.source o_vtx
);
    import spvg_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    spvg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    spvg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_branch_count (i_req.branch_count),
        .i_inner_radius (i_req.inner_radius),
        .i_out_ready    (o_vtx.ready),
        .o_out_valid    (o_vtx.valid),
        .o_vertex_index (o_vtx.vertex_index),
        .o_x_coord      (o_vtx.x_coord),
        .o_y_coord      (o_vtx.y_coord),
        .o_last_vertex  (o_vtx.last_vertex)
    );

    a_idle_holds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready && o_vtx.valid |-> o_vtx.last_vertex)
        else $error("beat pending while idle is not the last vertex");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vtx.valid && o_vtx.ready && !o_vtx.last_vertex |=>
            !o_vtx.valid || o_vtx.vertex_index == IDX_W'($past(o_vtx.vertex_index) + 1'b1))
        else $error("vertex index did not advance by one");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request taken while previous one in work");

endmodule

`default_nettype wire

// ----- tb/sv/star_vertex_checker.sv -----
// beat monitor with star vertex prediction and comparison for the vertex generator
`timescale 1ns / 1ps

module star_vertex_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    spvg_req_if   i_req,
    spvg_vtx_if   i_vtx,
    output int    o_fail_count,
    output int    o_vertices_due,
    output int    o_vertices_seen
);
    import spvg_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
    } t_vertex;

    localparam longint CORDIC_GAIN = 64'sd2608131497;
    localparam longint ARCTAN_STEP [0:31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };
    localparam longint COORD_MAX = (64'sd1 <<< COORD_FRAC_BITS) - 1;
    localparam longint COORD_MIN = -(64'sd1 <<< COORD_FRAC_BITS);

    t_vertex star_vertices_due[$];
    int      fail_total = 0;
    int      seen_total = 0;
    int      due_total  = 0;

    assign o_fail_count    = fail_total;
    assign o_vertices_due  = due_total;
    assign o_vertices_seen = seen_total;

    // scale to the output grid with round-half-up and saturation
    function automatic logic signed [COORD_W-1:0] fix_coord(input longint v, input logic inner,
                                                            input longint ratio);
        longint r;
        r = v;
        if (inner) begin
            r = (r * ratio + 64'sd32768) >>> 16;
        end
        r = (r + (64'sd1 <<< (31 - COORD_FRAC_BITS))) >>> (32 - COORD_FRAC_BITS);
        if (r > COORD_MAX) r = COORD_MAX;
        if (r < COORD_MIN) r = COORD_MIN;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return COORD_W'(r);
    endfunction

    // vertex k of a star with n branches, cordic in binary angle units
    function automatic t_vertex star_vertex(input int unsigned n, input longint ratio,
                                            input int unsigned k);
        t_vertex     v;
        longint      off;
        logic [31:0] angle;
        longint      x, y, z, dx, dy, c, s;
        int          i;
        off   = ((longint'(k) <<< 31) + longint'(n / 2)) / longint'(n);
        angle = 32'((64'sd1 <<< 30) + off);
        z     = longint'(angle[29:0]);
        x     = CORDIC_GAIN;
        y     = 0;
        for (i = 0; i < CORDIC_ITERATIONS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_STEP[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_STEP[i];
            end
        end
        case (angle[31:30])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
        v.idx  = IDX_W'(k);
        v.x    = fix_coord(c, k[0], ratio);
        v.y    = fix_coord(s, k[0], ratio);
        v.last = (k == 2 * n - 1);
        return v;
    endfunction

    function void check_field(input string name, input logic signed [31:0] want,
                              input logic signed [31:0] got);
        if (got !== want) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        int unsigned n;
        longint      ratio;
        int unsigned k;
        t_vertex     want;
        if (i_rst_n) begin
            if (i_vtx.valid && i_vtx.ready) begin
                seen_total++;
                if (star_vertices_due.size() == 0) begin
                    fail_total++;
                    $display("%0t: vertex beat with none expected, expected none actual idx %0d",
                             $time, i_vtx.vertex_index);
                end else begin
                    want = star_vertices_due.pop_front();
                    check_field("vertex_index", want.idx, i_vtx.vertex_index);
                    check_field("x_coord", want.x, i_vtx.x_coord);
                    check_field("y_coord", want.y, i_vtx.y_coord);
                    check_field("last_vertex", want.last, i_vtx.last_vertex);
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.branch_count < MIN_BRANCHES) n = MIN_BRANCHES;
                else if (i_req.branch_count > MAX_BRANCHES) n = MAX_BRANCHES;
                else n = i_req.branch_count;
                ratio = (i_req.inner_radius > RATIO_ONE) ? longint'(RATIO_ONE)
                                                         : longint'(i_req.inner_radius);
                for (k = 0; k < 2 * n; k++) begin
                    star_vertices_due.push_back(star_vertex(n, ratio, k));
                end
            end
            due_total = star_vertices_due.size();
        end
    end

endmodule

// ----- tb/sv/tb_star_polygon_vertex_generator.sv -----
// top of the vertex generator testbench: clock, reset, request and ready stimulus, verdict
`timescale 1ns / 1ps

module tb_star_polygon_vertex_generator;
    import spvg_pkg::*;

    localparam int STAR_REQUESTS = 200;
    localparam int HOLD_CYCLES   = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int send_idle_pct = 13;
    int recv_idle_pct = 83;
    bit hold_armed    = 1'b0;
    bit hold_done     = 1'b0;
    int requests_sent = 0;

    int mismatches;
    int vertices_due;
    int vertices_seen;

    spvg_req_if req_bus ();
    spvg_vtx_if vtx_bus ();

    star_polygon_vertex_generator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_vtx   (vtx_bus)
    );

    star_vertex_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req           (req_bus),
        .i_vtx           (vtx_bus),
        .o_fail_count    (mismatches),
        .o_vertices_due  (vertices_due),
        .o_vertices_seen (vertices_seen)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d vertices still due", vertices_due);
        $display("simulation failed");
        $finish;
    end

    // output side: random ready, one long stall when armed
    initial begin
        vtx_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !hold_done) begin
                vtx_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            vtx_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(input logic [BRANCH_W-1:0] branches,
                                input logic [RATIO_W-1:0] ratio);
        if ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_bus.valid        <= 1'b1;
        req_bus.branch_count <= branches;
        req_bus.inner_radius <= ratio;
        do @(posedge i_clk); while (!req_bus.ready);
        requests_sent++;
    endtask

    initial begin : stimulus
        logic [BRANCH_W-1:0] branches;
        logic [RATIO_W-1:0]  ratio;
        int                  pick;
        i_rst_n              <= 1'b0;
        req_bus.valid        <= 1'b0;
        req_bus.branch_count <= '0;
        req_bus.inner_radius <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // clamping of branch count and ratio, full-scale coordinates
        send_request(6'd0, 17'd0);
        send_request(6'd1, 17'd65536);
        send_request(6'd2, 17'd131071);
        send_request(6'd3, 17'd65537);
        send_request(6'd3, 17'd32768);
        send_request(6'd4, 17'd1);
        send_request(6'd5, 17'd65535);
        send_request(6'd6, 17'd98304);
        send_request(6'd7, 17'd131071);
        send_request(6'd31, 17'd43690);
        send_request(6'd32, 17'd65536);
        send_request(6'd33, 17'd21845);
        send_request(6'd63, 17'd0);

        hold_armed = 1'b1;
        for (int j = 0; j < STAR_REQUESTS; j++) begin
            if (j == STAR_REQUESTS / 3) begin
                send_idle_pct = 83;
                recv_idle_pct = 13;
            end else if (j == 2 * STAR_REQUESTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 60) branches = BRANCH_W'($urandom_range(8));
            else if (pick < 85) branches = BRANCH_W'($urandom_range(32, 9));
            else branches = BRANCH_W'($urandom_range(63, 33));
            pick = $urandom_range(99);
            if (pick < 70) ratio = RATIO_W'($urandom_range(65536));
            else if (pick < 80) ratio = RATIO_ONE;
            else ratio = RATIO_W'($urandom_range(131071));
            send_request(branches, ratio);
        end
        req_bus.valid <= 1'b0;

        @(negedge i_clk);
        while (vertices_due != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        $display("requests: %0d, branch counts 0..63 incl. clamping, ratios 0..131071",
                 requests_sent);
        $display("vertex beats: %0d, idling on either side, none, and a %0d-cycle stall",
                 vertices_seen, HOLD_CYCLES);
        if (mismatches == 0 && vertices_due == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
